// ===== src/ddpid_pkg.sv =====
package ddpid_pkg;

    localparam int POS_W   = 32;   // encoder positions, errors, targets (Q.8 deg)
    localparam int GAIN_W  = 24;   // unsigned Q0.24 gains
    localparam int FRAC_W  = 24;   // gain fraction bits
    localparam int VOLT_W  = 24;   // Q15.8 volts
    localparam int SUM_W   = 48;   // turn integral
    localparam int NUM_POS = 6;

    localparam int MAX_VOLTS = 3072;
    localparam int MIN_VOLTS = 333;

    // reciprocal of 3 for 32-bit unsigned operands: q = (u * RECIP3) >> 33
    localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

    localparam logic [GAIN_W-1:0] DRIVE_KP_RST  = 24'd100663;
    localparam logic [GAIN_W-1:0] DRIVE_KD_RST  = 24'd50332;
    localparam logic [GAIN_W-1:0] TURN_KP_RST   = 24'd16777;
    localparam logic [GAIN_W-1:0] TURN_KI_RST   = 24'd83886;
    localparam logic [GAIN_W-1:0] TURN_KD_RST   = 24'd839;
    localparam logic [GAIN_W-1:0] ADJUST_KP_RST = 24'd1342177;

    typedef enum logic [2:0] {
        CFG_DRIVE_TARGET = 3'd0,
        CFG_TURN_TARGET  = 3'd1,
        CFG_DRIVE_KP     = 3'd2,
        CFG_DRIVE_KD     = 3'd3,
        CFG_TURN_KP      = 3'd4,
        CFG_TURN_KI      = 3'd5,
        CFG_TURN_KD      = 3'd6,
        CFG_ADJUST_KP    = 3'd7
    } t_cfg_idx;

    // load enables of the four side-average pipeline stages
    typedef struct packed {
        logic mul;
        logic sum;
        logic fold;
        logic fix;
    } t_avg_en;

endpackage

// ===== src/ddpid_side_avg.sv =====
// Mean of three signed encoder positions, truncated toward zero. Four stages.
module ddpid_side_avg (
    input  logic                                  i_clk,
    input  ddpid_pkg::t_avg_en                    i_en,
    input  logic signed [ddpid_pkg::POS_W-1:0]    i_pos0,
    input  logic signed [ddpid_pkg::POS_W-1:0]    i_pos1,
    input  logic signed [ddpid_pkg::POS_W-1:0]    i_pos2,
    output logic signed [ddpid_pkg::POS_W-1:0]    o_mean
);

    logic signed [ddpid_pkg::POS_W-1:0] pos [3];
    logic [ddpid_pkg::POS_W-1:0]        u   [3];
    logic [2*ddpid_pkg::POS_W-1:0]      prod [3];

    // stage 1: per-operand quotient by 3 of the offset-binary value
    logic [ddpid_pkg::POS_W-2:0] r_q   [3];
    logic [1:0]                  r_ulo [3];

    // stage 2: summed quotients and remainders
    logic [1:0]                  n_r [3];
    logic [ddpid_pkg::POS_W:0]   r_qsum;
    logic [2:0]                  r_rsum;

    // stage 3: floor quotient and its remainder
    logic [1:0]                  qadj;
    logic [1:0]                  radj;
    logic [ddpid_pkg::POS_W+1:0] fq_w;
    logic signed [ddpid_pkg::POS_W-1:0] r_fq;
    logic [1:0]                  r_rem;

    // stage 4
    logic signed [ddpid_pkg::POS_W-1:0] r_mean;

    assign pos[0] = i_pos0;
    assign pos[1] = i_pos1;
    assign pos[2] = i_pos2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            u[i]    = {~pos[i][ddpid_pkg::POS_W-1], pos[i][ddpid_pkg::POS_W-2:0]};
            prod[i] = u[i] * ddpid_pkg::RECIP3;
            // 3q mod 4 = q + 2q mod 4
            n_r[i]  = r_ulo[i] - r_q[i][1:0] - {r_q[i][0], 1'b0};
        end
    end

    // remainder sum 0..6 folded back into quotient and remainder
    always_comb begin
        case (r_rsum)
            3'd0, 3'd1, 3'd2: begin
                qadj = 2'd0;
                radj = r_rsum[1:0];
            end
            3'd3, 3'd4, 3'd5: begin
                qadj = 2'd1;
                radj = 2'(r_rsum - 3'd3);
            end
            3'd6: begin
                qadj = 2'd2;
                radj = 2'd0;
            end
            default: begin
                qadj = 2'd0;
                radj = 2'd0;
            end
        endcase
        // undo the three 2^31 offsets: sum(u) = sum(x) + 3*2^31
        fq_w = {1'b0, r_qsum} + {{ddpid_pkg::POS_W{1'b0}}, qadj}
             - {2'b00, 1'b1, {(ddpid_pkg::POS_W-1){1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            for (int i = 0; i < 3; i++) begin
                r_q[i]   <= prod[i][2*ddpid_pkg::POS_W-1:ddpid_pkg::POS_W+1];
                r_ulo[i] <= u[i][1:0];
            end
        end
        if (i_en.sum) begin
            r_qsum <= {2'b00, r_q[0]} + {2'b00, r_q[1]} + {2'b00, r_q[2]};
            r_rsum <= {1'b0, n_r[0]} + {1'b0, n_r[1]} + {1'b0, n_r[2]};
        end
        if (i_en.fold) begin
            r_fq  <= fq_w[ddpid_pkg::POS_W-1:0];
            r_rem <= radj;
        end
        if (i_en.fix) begin
            // floor to truncation: negative with a remainder moves up by one
            r_mean <= r_fq + ddpid_pkg::POS_W'(r_fq[ddpid_pkg::POS_W-1] && (r_rem != 2'd0));
        end
    end

    assign o_mean = r_mean;

endmodule

// ===== src/differential_drive_pid.sv =====
// Differential-drive position controller. One beat in per control tick carries six
// encoder positions (Q.8 degrees); one beat out carries left and right voltages
// (Q15.8, saturated to 24 bits), drive_done, turn_done and stop_motors. Each side is
// averaged over its three encoders; a drive PD loop acts on the mean travel, a turn
// PID loop on the left-minus-right difference, and a P-only straightness term on the
// right-minus-left difference, which is used instead of the turn loop unless the turn
// target is positive. Loop outputs get the minimum/maximum clamps signed by the
// target, and a held heading correction (refreshed while the turn target is nonzero)
// is added. The block is a 13-stage pipeline: it takes a beat every clock, with
// stalls on the output only holding back the stages that are full. The loop state
// (last errors, integral, held correction) lives at stage 7 and is advanced there
// once per beat, so the rate of one beat per cycle is set by that single stage.
// Gains and targets are to be written by the user on the config port only while
// no beat is in flight; the block does not enforce this. The port is always ready.
module differential_drive_pid (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config write channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] left_back_pos, [63:32] left_mid_pos, [95:64] left_front_pos,
    // [127:96] right_back_pos, [159:128] right_mid_pos, [191:160] right_front_pos
    input  logic [191:0] s_axis_tdata,
    // output stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [23:0] left_volts, [47:24] right_volts, [48] drive_done, [49] turn_done,
    // [50] stop_motors, [55:51] zero
    output logic [55:0]  m_axis_tdata
);

    localparam int PW    = ddpid_pkg::POS_W;
    localparam int GW    = ddpid_pkg::GAIN_W;
    localparam int FW    = ddpid_pkg::FRAC_W;
    localparam int VW    = ddpid_pkg::VOLT_W;
    localparam int SW    = ddpid_pkg::SUM_W;
    localparam int NSTG  = 13;
    localparam int LAST  = NSTG - 1;
    localparam int DPW   = 35;   // drive power after the gain shift
    localparam int TPW   = 51;   // turn power
    localparam int OUTW  = 53;   // final voltage sum before saturation

    // ---------------- config registers ----------------
    logic signed [PW-1:0] r_drive_tgt;
    logic signed [PW-1:0] r_turn_tgt;
    logic [GW-1:0]        r_drive_kp;
    logic [GW-1:0]        r_drive_kd;
    logic [GW-1:0]        r_turn_kp;
    logic [GW-1:0]        r_turn_ki;
    logic [GW-1:0]        r_turn_kd;
    logic [GW-1:0]        r_adjust_kp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_tgt <= '0;
            r_turn_tgt  <= '0;
            r_drive_kp  <= ddpid_pkg::DRIVE_KP_RST;
            r_drive_kd  <= ddpid_pkg::DRIVE_KD_RST;
            r_turn_kp   <= ddpid_pkg::TURN_KP_RST;
            r_turn_ki   <= ddpid_pkg::TURN_KI_RST;
            r_turn_kd   <= ddpid_pkg::TURN_KD_RST;
            r_adjust_kp <= ddpid_pkg::ADJUST_KP_RST;
        end else if (i_cfg_valid) begin
            case (ddpid_pkg::t_cfg_idx'(i_cfg_index))
                ddpid_pkg::CFG_DRIVE_TARGET: r_drive_tgt <= i_cfg_data;
                ddpid_pkg::CFG_TURN_TARGET:  r_turn_tgt  <= i_cfg_data;
                ddpid_pkg::CFG_DRIVE_KP:     r_drive_kp  <= i_cfg_data[GW-1:0];
                ddpid_pkg::CFG_DRIVE_KD:     r_drive_kd  <= i_cfg_data[GW-1:0];
                ddpid_pkg::CFG_TURN_KP:      r_turn_kp   <= i_cfg_data[GW-1:0];
                ddpid_pkg::CFG_TURN_KI:      r_turn_ki   <= i_cfg_data[GW-1:0];
                ddpid_pkg::CFG_TURN_KD:      r_turn_kd   <= i_cfg_data[GW-1:0];
                ddpid_pkg::CFG_ADJUST_KP:    r_adjust_kp <= i_cfg_data[GW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- helpers ----------------
    function automatic logic signed [PW-1:0] sat32(input logic signed [PW+1:0] x);
        logic signed [PW+1:0] hi;
        logic signed [PW+1:0] lo;
        hi = {3'b000, {(PW-1){1'b1}}};
        lo = {3'b111, {(PW-1){1'b0}}};
        if (x > hi)      sat32 = hi[PW-1:0];
        else if (x < lo) sat32 = lo[PW-1:0];
        else             sat32 = x[PW-1:0];
    endfunction

    function automatic logic signed [SW-1:0] sat48(input logic signed [SW:0] x);
        if (x[SW] != x[SW-1]) sat48 = {x[SW], {(SW-1){~x[SW]}}};
        else                  sat48 = x[SW-1:0];
    endfunction

    function automatic logic signed [VW-1:0] sat24(input logic signed [OUTW-1:0] x);
        logic signed [OUTW-1:0] hi;
        logic signed [OUTW-1:0] lo;
        hi = {{(OUTW-VW+1){1'b0}}, {(VW-1){1'b1}}};
        lo = {{(OUTW-VW+1){1'b1}}, {(VW-1){1'b0}}};
        if (x > hi)      sat24 = hi[VW-1:0];
        else if (x < lo) sat24 = lo[VW-1:0];
        else             sat24 = x[VW-1:0];
    endfunction

    // min-magnitude then max clamp, signed by the drive target
    function automatic logic signed [DPW-1:0] clamp_drive(input logic signed [DPW-1:0] p,
                                                          input logic signed [PW-1:0] tgt);
        logic signed [DPW-1:0] q;
        logic [DPW-1:0]        m;
        q = p;
        m = p[DPW-1] ? DPW'(-p) : DPW'(p);
        if (m <= DPW'(ddpid_pkg::MIN_VOLTS) && m != '0) begin
            if (tgt > 0)      q = DPW'(ddpid_pkg::MIN_VOLTS);
            else if (tgt < 0) q = DPW'(0) - DPW'(ddpid_pkg::MIN_VOLTS);
        end
        m = q[DPW-1] ? DPW'(-q) : DPW'(q);
        if (m >= DPW'(ddpid_pkg::MAX_VOLTS)) begin
            if (tgt > 0)      q = DPW'(ddpid_pkg::MAX_VOLTS);
            else if (tgt < 0) q = DPW'(0) - DPW'(ddpid_pkg::MAX_VOLTS);
        end
        clamp_drive = q;
    endfunction

    // max clamp only, signed by the turn target
    function automatic logic signed [TPW-1:0] clamp_turn(input logic signed [TPW-1:0] p,
                                                         input logic signed [PW-1:0] tgt);
        logic signed [TPW-1:0] q;
        logic [TPW-1:0]        m;
        q = p;
        m = p[TPW-1] ? TPW'(-p) : TPW'(p);
        if (m >= TPW'(ddpid_pkg::MAX_VOLTS)) begin
            if (tgt > 0)      q = TPW'(ddpid_pkg::MAX_VOLTS);
            else if (tgt < 0) q = TPW'(0) - TPW'(ddpid_pkg::MAX_VOLTS);
        end
        clamp_turn = q;
    endfunction

    // ---------------- pipeline flow control ----------------
    // a stage loads when it is empty or its content moves on
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;

    always_comb begin
        en[LAST] = !r_vld[LAST] || m_axis_tready;
        for (int k = LAST - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= s_axis_tvalid;
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = r_vld[LAST];

    // ---------------- stage 0: input register ----------------
    logic signed [PW-1:0] r_s0_pos [ddpid_pkg::NUM_POS];

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int i = 0; i < ddpid_pkg::NUM_POS; i++) begin
                r_s0_pos[i] <= s_axis_tdata[i*PW +: PW];
            end
        end
    end

    // ---------------- stages 1..4: side means ----------------
    ddpid_pkg::t_avg_en   avg_en;
    logic signed [PW-1:0] left_mean;
    logic signed [PW-1:0] right_mean;

    assign avg_en.mul  = en[1];
    assign avg_en.sum  = en[2];
    assign avg_en.fold = en[3];
    assign avg_en.fix  = en[4];

    ddpid_side_avg u_left (
        .i_clk  (i_clk),
        .i_en   (avg_en),
        .i_pos0 (r_s0_pos[0]),
        .i_pos1 (r_s0_pos[1]),
        .i_pos2 (r_s0_pos[2]),
        .o_mean (left_mean)
    );

    ddpid_side_avg u_right (
        .i_clk  (i_clk),
        .i_en   (avg_en),
        .i_pos0 (r_s0_pos[3]),
        .i_pos1 (r_s0_pos[4]),
        .i_pos2 (r_s0_pos[5]),
        .o_mean (right_mean)
    );

    // ---------------- stage 5: mean travel, difference, magnitudes ----------------
    logic signed [PW:0]   lr_sum;
    logic signed [PW:0]   lr_sum_rnd;
    logic signed [PW-1:0] r_s5_avg;
    logic signed [PW:0]   r_s5_diff;
    logic [PW:0]          r_s5_abs_l;
    logic [PW:0]          r_s5_abs_r;

    always_comb begin
        lr_sum     = {left_mean[PW-1], left_mean} + {right_mean[PW-1], right_mean};
        // halve toward zero: odd negative sums round up
        lr_sum_rnd = lr_sum + (PW+1)'(lr_sum[PW] & lr_sum[0]);
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_s5_avg   <= lr_sum_rnd[PW:1];
            r_s5_diff  <= {left_mean[PW-1], left_mean} - {right_mean[PW-1], right_mean};
            r_s5_abs_l <= left_mean[PW-1]  ? (PW+1)'(-{left_mean[PW-1], left_mean})
                                           : (PW+1)'({1'b0, left_mean});
            r_s5_abs_r <= right_mean[PW-1] ? (PW+1)'(-{right_mean[PW-1], right_mean})
                                           : (PW+1)'({1'b0, right_mean});
        end
    end

    // ---------------- stage 6: errors, done flags ----------------
    logic signed [PW+1:0] ed_w;
    logic signed [PW+1:0] et_w;
    logic signed [PW+1:0] hc_w;
    logic [PW:0]          abs_avg;
    logic [PW:0]          abs_dtgt;
    logic [PW+1:0]        abs_diff;
    logic [PW+1:0]        abs_ttgt;

    logic signed [PW-1:0] r_s6_ed;
    logic signed [PW-1:0] r_s6_et;
    logic signed [PW-1:0] r_s6_hc;
    logic signed [PW:0]   r_s6_nd;     // right minus left
    logic                 r_s6_ddone;
    logic                 r_s6_tdone;

    always_comb begin
        ed_w = (PW+2)'(r_drive_tgt) - (PW+2)'(r_s5_avg);
        et_w = (PW+2)'(r_turn_tgt)  - (PW+2)'(r_s5_diff);
        hc_w = $signed({1'b0, r_s5_abs_l}) - $signed({1'b0, r_s5_abs_r});
        abs_avg  = r_s5_avg[PW-1]    ? (PW+1)'(-(PW+1)'(r_s5_avg))    : (PW+1)'(r_s5_avg);
        abs_dtgt = r_drive_tgt[PW-1] ? (PW+1)'(-(PW+1)'(r_drive_tgt)) : (PW+1)'(r_drive_tgt);
        abs_diff = r_s5_diff[PW]     ? (PW+2)'(-(PW+2)'(r_s5_diff))   : (PW+2)'(r_s5_diff);
        abs_ttgt = r_turn_tgt[PW-1]  ? (PW+2)'(-(PW+2)'(r_turn_tgt))  : (PW+2)'(r_turn_tgt);
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_s6_ed    <= sat32(ed_w);
            r_s6_et    <= sat32(et_w);
            r_s6_hc    <= sat32(hc_w);
            r_s6_nd    <= (PW+1)'(0) - r_s5_diff;
            r_s6_ddone <= abs_avg >= abs_dtgt;
            r_s6_tdone <= abs_diff >= abs_ttgt;
        end
    end

    // ---------------- stage 7: loop state ----------------
    logic signed [PW-1:0] r_last_de;
    logic signed [PW-1:0] r_last_te;
    logic signed [SW-1:0] r_tsum;
    logic signed [PW-1:0] r_held;

    logic signed [SW-1:0] n_tsum;
    logic signed [PW-1:0] n_held;
    logic                 s7_take;

    logic signed [PW-1:0] r_s7_ed;
    logic signed [PW:0]   r_s7_ded;
    logic signed [PW-1:0] r_s7_et;
    logic signed [PW:0]   r_s7_det;
    logic signed [SW-1:0] r_s7_sum;
    logic signed [PW-1:0] r_s7_held;
    logic signed [PW:0]   r_s7_nd;
    logic                 r_s7_ddone;
    logic                 r_s7_tdone;

    always_comb begin
        s7_take = en[7] && r_vld[6];
        n_tsum  = sat48((SW+1)'(r_tsum) + (SW+1)'(r_s6_et));
        n_held  = (r_turn_tgt != '0) ? r_s6_hc : r_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_de <= '0;
            r_last_te <= '0;
            r_tsum    <= '0;
            r_held    <= '0;
        end else if (s7_take) begin
            r_last_de <= r_s6_ed;
            r_last_te <= r_s6_et;
            r_tsum    <= n_tsum;
            r_held    <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_s7_ed    <= r_s6_ed;
            r_s7_ded   <= (PW+1)'(r_s6_ed) - (PW+1)'(r_last_de);
            r_s7_et    <= r_s6_et;
            r_s7_det   <= (PW+1)'(r_s6_et) - (PW+1)'(r_last_te);
            r_s7_sum   <= n_tsum;
            r_s7_held  <= n_held;
            r_s7_nd    <= r_s6_nd;
            r_s7_ddone <= r_s6_ddone;
            r_s7_tdone <= r_s6_tdone;
        end
    end

    // ---------------- stage 8: gain products ----------------
    logic signed [PW+GW:0]   r_s8_pd1;   // ed  * drive kP
    logic signed [PW+GW+1:0] r_s8_pd2;   // ded * drive kD
    logic signed [PW+GW:0]   r_s8_pt1;   // et  * turn kP
    logic signed [PW+GW+1:0] r_s8_pt2;   // det * turn kD
    logic signed [PW+GW+1:0] r_s8_pa;    // (R-L) * adjust kP
    logic signed [SW:0]      r_s8_pih;   // integral upper part * kI
    logic [SW-1:0]           r_s8_pil;   // integral fraction * kI
    logic signed [PW-1:0]    r_s8_held;
    logic                    r_s8_ddone;
    logic                    r_s8_tdone;

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r_s8_pd1   <= r_s7_ed  * $signed({1'b0, r_drive_kp});
            r_s8_pd2   <= r_s7_ded * $signed({1'b0, r_drive_kd});
            r_s8_pt1   <= r_s7_et  * $signed({1'b0, r_turn_kp});
            r_s8_pt2   <= r_s7_det * $signed({1'b0, r_turn_kd});
            r_s8_pa    <= r_s7_nd  * $signed({1'b0, r_adjust_kp});
            r_s8_pih   <= $signed(r_s7_sum[SW-1:FW]) * $signed({1'b0, r_turn_ki});
            r_s8_pil   <= r_s7_sum[FW-1:0] * r_turn_ki;
            r_s8_held  <= r_s7_held;
            r_s8_ddone <= r_s7_ddone;
            r_s8_tdone <= r_s7_tdone;
        end
    end

    // ---------------- stage 9: floor shifts ----------------
    logic signed [PW+GW+2:0] dsum;
    logic signed [PW+GW+2:0] tsum;
    logic signed [TPW-2:0]   ti_w;

    logic signed [DPW-1:0]   r_s9_drive;
    logic signed [DPW-1:0]   r_s9_tpd;
    logic signed [PW+1:0]    r_s9_adj;
    logic signed [TPW-2:0]   r_s9_ti;
    logic signed [PW-1:0]    r_s9_held;
    logic                    r_s9_ddone;
    logic                    r_s9_tdone;

    always_comb begin
        dsum = (PW+GW+3)'(r_s8_pd1) + (PW+GW+3)'(r_s8_pd2);
        tsum = (PW+GW+3)'(r_s8_pt1) + (PW+GW+3)'(r_s8_pt2);
        ti_w = (TPW-1)'(r_s8_pih) + $signed({{(TPW-1-(SW-FW)){1'b0}}, r_s8_pil[SW-1:FW]});
    end

    always_ff @(posedge i_clk) begin
        if (en[9]) begin
            r_s9_drive <= dsum[PW+GW+2:FW];
            r_s9_tpd   <= tsum[PW+GW+2:FW];
            r_s9_adj   <= r_s8_pa[PW+GW+1:FW];
            r_s9_ti    <= ti_w;
            r_s9_held  <= r_s8_held;
            r_s9_ddone <= r_s8_ddone;
            r_s9_tdone <= r_s8_tdone;
        end
    end

    // ---------------- stage 10: turn power ----------------
    logic signed [DPW-1:0] r_s10_drive;
    logic signed [TPW-1:0] r_s10_turn;
    logic signed [PW+1:0]  r_s10_adj;
    logic signed [PW-1:0]  r_s10_held;
    logic                  r_s10_ddone;
    logic                  r_s10_tdone;

    always_ff @(posedge i_clk) begin
        if (en[10]) begin
            r_s10_drive <= r_s9_drive;
            r_s10_turn  <= TPW'(r_s9_tpd) + TPW'(r_s9_ti);
            r_s10_adj   <= r_s9_adj;
            r_s10_held  <= r_s9_held;
            r_s10_ddone <= r_s9_ddone;
            r_s10_tdone <= r_s9_tdone;
        end
    end

    // ---------------- stage 11: clamps and turn select ----------------
    logic signed [DPW-1:0] dp_c;
    logic signed [TPW-1:0] tp_c;

    logic signed [DPW-1:0] r_s11_dp;
    logic signed [TPW-1:0] r_s11_tv;
    logic signed [PW-1:0]  r_s11_held;
    logic                  r_s11_ddone;
    logic                  r_s11_tdone;

    always_comb begin
        // the drive clamp only applies on a straight move, the turn clamp on a pivot
        dp_c = (r_turn_tgt == '0)  ? clamp_drive(r_s10_drive, r_drive_tgt) : r_s10_drive;
        tp_c = (r_drive_tgt == '0) ? clamp_turn(r_s10_turn, r_turn_tgt)    : r_s10_turn;
    end

    always_ff @(posedge i_clk) begin
        if (en[11]) begin
            r_s11_dp    <= dp_c;
            r_s11_tv    <= (r_turn_tgt > 0) ? tp_c : TPW'(r_s10_adj);
            r_s11_held  <= r_s10_held;
            r_s11_ddone <= r_s10_ddone;
            r_s11_tdone <= r_s10_tdone;
        end
    end

    // ---------------- stage 12: output register ----------------
    logic signed [OUTW-1:0] lv_w;
    logic signed [OUTW-1:0] rv_w;
    logic                   stop_w;

    logic signed [VW-1:0]   r_out_left;
    logic signed [VW-1:0]   r_out_right;
    logic                   r_out_ddone;
    logic                   r_out_tdone;
    logic                   r_out_stop;

    always_comb begin
        lv_w = OUTW'(r_s11_dp) + OUTW'(r_s11_tv) + OUTW'(r_s11_held);
        rv_w = OUTW'(r_s11_dp) - OUTW'(r_s11_tv) - OUTW'(r_s11_held);
        // stop: straight move reached its travel, or pivot reached its angle
        stop_w = ((r_drive_tgt != '0) && r_s11_ddone && (r_turn_tgt == '0)) ||
                 ((r_drive_tgt == '0) && r_s11_tdone && (r_turn_tgt != '0));
    end

    always_ff @(posedge i_clk) begin
        if (en[LAST]) begin
            r_out_left  <= sat24(lv_w);
            r_out_right <= sat24(rv_w);
            r_out_ddone <= r_s11_ddone;
            r_out_tdone <= r_s11_tdone;
            r_out_stop  <= stop_w;
        end
    end

    assign m_axis_tdata = {5'b00000, r_out_stop, r_out_tdone, r_out_ddone,
                           r_out_right, r_out_left};

endmodule
